FILE: rtl/pe_pkg.sv
// Package for the polynomial evaluator: widths, register indexes, the beat
// that travels along the cell chain and the saturation limits.
// No dependencies.
`timescale 1ns / 1ps

package pe_pkg;

  // Polynomial size and number format
  localparam int MAX_DEGREE = 6;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int DEG_W      = 3;

  // Register map
  localparam int NUM_COEFF = MAX_DEGREE + 1;
  localparam int NUM_REGS  = MAX_DEGREE + 2;
  localparam int IDX_W     = $clog2(NUM_REGS);
  localparam int CIDX_W    = (NUM_COEFF > 1) ? $clog2(NUM_COEFF) : 1;

  localparam logic [IDX_W-1:0] REG_DEGREE     = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COEFF_BASE = IDX_W'(1);

  // Datapath widths
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = PROD_W - FRAC_BITS + 1;
  localparam int PIPE_DEPTH = 2 * NUM_COEFF;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // One point in flight: the point, the running Horner sum, sticky overflow
  typedef struct packed {
    word_t x;
    word_t acc;
    logic  ovf;
  } pe_beat_t;

endpackage

FILE: rtl/pe_cfg.sv
// Configuration registers of the polynomial evaluator: degree and coefficients,
// plus the per-coefficient enable mask derived from the clamped degree.
// Depends on pe_pkg.
`timescale 1ns / 1ps

module pe_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [pe_pkg::IDX_W-1:0]     cfg_index,
  input  logic [pe_pkg::DATA_W-1:0]    cfg_wr_data,
  output pe_pkg::word_t                coeffs [pe_pkg::NUM_COEFF],
  output logic [pe_pkg::NUM_COEFF-1:0] coeff_active
);
  import pe_pkg::*;

  logic [DEG_W-1:0]  degree;
  logic [DEG_W-1:0]  degree_eff;
  word_t             coeff_regs [NUM_COEFF];
  logic [CIDX_W-1:0] coeff_sel;

  assign coeff_sel = CIDX_W'(cfg_index - REG_COEFF_BASE);

  // Register writes; indexes past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= '0;
      for (int k = 0; k < NUM_COEFF; k++) begin
        coeff_regs[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_DEGREE) begin
        degree <= cfg_wr_data[DEG_W-1:0];
      end else if (int'(cfg_index) < NUM_REGS) begin
        coeff_regs[coeff_sel] <= word_t'(cfg_wr_data);
      end
    end
  end

  // Degree above the supported maximum acts as the maximum
  always_comb begin
    if (int'(degree) > MAX_DEGREE) begin
      degree_eff = DEG_W'(MAX_DEGREE);
    end else begin
      degree_eff = degree;
    end
  end

  // A coefficient takes part when its power is within the degree
  always_comb begin
    for (int k = 0; k < NUM_COEFF; k++) begin
      coeffs[k]       = coeff_regs[k];
      coeff_active[k] = (DEG_W'(k) <= degree_eff);
    end
  end

endmodule

FILE: rtl/pe_cell.sv
// One Horner step of the evaluator: a multiply stage and an accumulate stage
// with saturation, each a register with its own valid. Depends on pe_pkg.
`timescale 1ns / 1ps

module pe_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pe_pkg::pe_beat_t in_beat,
  input  pe_pkg::word_t    coeff,
  input  logic             active,
  output logic             out_valid,
  input  logic             out_ready,
  output pe_pkg::pe_beat_t out_beat
);
  import pe_pkg::*;

  // Multiply stage
  logic                     mul_valid;
  logic                     mul_ready;
  word_t                    mul_x;
  word_t                    mul_acc;
  logic                     mul_ovf;
  logic signed [PROD_W-1:0] mul_prod;

  // Accumulate stage
  logic                     acc_valid;
  logic                     acc_ready;
  pe_beat_t                 acc_beat;
  pe_beat_t                 acc_beat_next;

  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-DATA_W:0]    sum_hi;
  logic                     sum_fits;

  // Each stage moves when it is empty or the one after it moves
  assign acc_ready = !acc_valid || out_ready;
  assign mul_ready = !mul_valid || acc_ready;
  assign in_ready  = mul_ready;

  // Stage 1: full-width product of running sum and point
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ready) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && mul_ready) begin
      mul_x    <= in_beat.x;
      mul_acc  <= in_beat.acc;
      mul_ovf  <= in_beat.ovf;
      mul_prod <= in_beat.acc * in_beat.x;
    end
  end

  // Stage 2: floor shift, add coefficient, clamp to the word range
  always_comb begin
    sum      = SUM_W'($signed(mul_prod[PROD_W-1:FRAC_BITS])) + SUM_W'(coeff);
    sum_hi   = sum[SUM_W-1:DATA_W-1];
    sum_fits = (&sum_hi) || !(|sum_hi);

    acc_beat_next.x = mul_x;
    if (!active) begin
      acc_beat_next.acc = mul_acc;
      acc_beat_next.ovf = mul_ovf;
    end else if (sum_fits) begin
      acc_beat_next.acc = sum[DATA_W-1:0];
      acc_beat_next.ovf = mul_ovf;
    end else begin
      acc_beat_next.acc = sum[SUM_W-1] ? WORD_MIN : WORD_MAX;
      acc_beat_next.ovf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (acc_ready) begin
      acc_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid && acc_ready) begin
      acc_beat <= acc_beat_next;
    end
  end

  assign out_valid = acc_valid;
  assign out_beat  = acc_beat;

endmodule

FILE: rtl/polynomial_evaluator_unit.sv
// Top level of the polynomial evaluator: configuration registers and a chain
// of Horner cells, highest power first. Depends on pe_pkg, pe_cfg, pe_cell.
//
//   channel  signals                              direction
//   input    in_valid/in_ready, point_x           in
//   output   out_valid/out_ready, poly_value, overflow  out
//   config   cfg_wr_en, cfg_index, cfg_wr_data    in, write only
//
// One point enters per cycle while the chain is not held off; each result passes
// two registers per cell (multiply register, accumulate register) across 7 cells.
// The chain starts from a zero sum; cells above the degree pass the beat on.
// Reset clears all valid bits and sets degree and coefficients to zero.
// When out_ready is low the results back up cell by cell; empty slots close
// up, so input is held off only once every stage holds a beat.
`timescale 1ns / 1ps

module polynomial_evaluator_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pe_pkg::word_t             point_x,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pe_pkg::word_t             poly_value,
  output logic                      overflow,
  input  logic                      cfg_wr_en,
  input  logic [pe_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pe_pkg::DATA_W-1:0] cfg_wr_data
);
  import pe_pkg::*;

  word_t                  coeffs [NUM_COEFF];
  logic [NUM_COEFF-1:0]   coeff_active;

  pe_beat_t               link_beat  [NUM_COEFF+1];
  logic                   link_valid [NUM_COEFF+1];
  logic                   link_ready [NUM_COEFF+1];

  pe_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .coeffs       (coeffs),
    .coeff_active (coeff_active)
  );

  // Chain head: the point with an empty running sum
  assign link_valid[0]    = in_valid;
  assign in_ready         = link_ready[0];
  assign link_beat[0].x   = point_x;
  assign link_beat[0].acc = '0;
  assign link_beat[0].ovf = 1'b0;

  // Cell j folds in the coefficient of power MAX_DEGREE - j
  for (genvar j = 0; j < NUM_COEFF; j++) begin : g_cell
    pe_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[j]),
      .in_ready  (link_ready[j]),
      .in_beat   (link_beat[j]),
      .coeff     (coeffs[MAX_DEGREE-j]),
      .active    (coeff_active[MAX_DEGREE-j]),
      .out_valid (link_valid[j+1]),
      .out_ready (link_ready[j+1]),
      .out_beat  (link_beat[j+1])
    );
  end

  // Chain tail drives the result channel
  assign out_valid             = link_valid[NUM_COEFF];
  assign link_ready[NUM_COEFF] = out_ready;
  assign poly_value            = link_beat[NUM_COEFF].acc;
  assign overflow              = link_beat[NUM_COEFF].ovf;

endmodule

FILE: rtl/pe_checker.sv
// Port-level checks for polynomial_evaluator_unit, attached by bind.
// Depends on pe_pkg.
`timescale 1ns / 1ps

module pe_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input pe_pkg::word_t             poly_value,
  input logic                      overflow
);
  import pe_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic [CNT_W-1:0] inflight;
  logic [CNT_W-1:0] inflight_next;

  // Beats accepted but not yet delivered
  always_comb begin
    inflight_next = inflight + CNT_W'(in_valid && in_ready)
                    - CNT_W'(out_valid && out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(poly_value) && $stable(overflow))
    else $error("stalled result changed");

  // No result without a point behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result without an accepted point");

  // Input is taken while any stage of the chain is free
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    int'(inflight) < PIPE_DEPTH |-> in_ready)
    else $error("input held off with room in the chain");

  // The chain never holds more beats than it has stages
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    int'(inflight) <= PIPE_DEPTH)
    else $error("more beats in flight than stages");

endmodule

bind polynomial_evaluator_unit pe_checker u_pe_checker (.*);

FILE: tb/tb.sv
// Testbench for polynomial_evaluator_unit: Horner evaluation of signed Q16.16
// points with per-step saturation, checked beat by beat against a local predictor.
// Depends on pe_pkg and the RTL of polynomial_evaluator_unit.
`timescale 1ns / 1ps

module tb;
  import pe_pkg::*;

  localparam int    RANDOM_ITEMS = 450;
  localparam int    RX_HOLD_CYC  = 80;
  localparam word_t Q_ONE        = 32'sh0001_0000;

  typedef struct {
    word_t value;
    logic  ovf;
  } poly_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  word_t             point_x = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  word_t             poly_value;
  logic              overflow;
  logic              cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0] cfg_wr_data = '0;

  // Shadow copy of the register file
  logic [DEG_W-1:0]  cur_degree = '0;
  word_t             cur_coeff [0:MAX_DEGREE];

  word_t             pending_points [$];
  poly_result_t      expected_values [$];
  int                accepted_cnt = 0;
  int                mismatch_cnt = 0;
  int                tx_gap = 0;
  int                rx_gap = 0;
  logic              rx_hold = 1'b0;
  logic              calm = 1'b0;

  polynomial_evaluator_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .point_x     (point_x),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .poly_value  (poly_value),
    .overflow    (overflow),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Horner's rule on the shadow registers: exact product, floor shift,
  // saturate after every step, sticky overflow.
  function automatic poly_result_t horner_eval(input word_t x);
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    logic signed [63:0] sum;
    int                 top;
    int                 k;
    poly_result_t       res;
    top = (int'(cur_degree) > MAX_DEGREE) ? MAX_DEGREE : int'(cur_degree);
    acc = 64'(cur_coeff[top]);
    res.ovf = 1'b0;
    for (k = top - 1; k >= 0; k--) begin
      prod = acc * 64'(x);
      sum = (prod >>> FRAC_BITS) + 64'(cur_coeff[k]);
      if (sum > 64'sd2147483647) begin
        acc = 64'sd2147483647;
        res.ovf = 1'b1;
      end else if (sum < -64'sd2147483648) begin
        acc = -64'sd2147483648;
        res.ovf = 1'b1;
      end else begin
        acc = sum;
      end
    end
    res.value = word_t'(acc[31:0]);
    return res;
  endfunction

  // Uniform value in roughly +/- 2^bits raw units
  function automatic word_t rand_scaled(input int bits);
    return word_t'($urandom) >>> (31 - bits);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < 50)
      $display("[%0t] %s", $time, msg);
    mismatch_cnt++;
  endtask

  // One register write, mirrored into the shadow copy
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    if (idx == REG_DEGREE)
      cur_degree = data[DEG_W-1:0];
    else
      cur_coeff[idx - REG_COEFF_BASE] = word_t'(data);
  endtask

  // Wait until every queued point went in and every result came back
  task automatic drain();
    while (pending_points.size() != 0 || in_valid || expected_values.size() != 0)
      @(negedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic push_point(input word_t x);
    pending_points.push_back(x);
  endtask

  // Driver: launches queued points, records predictions on accepted beats
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      point_x  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_values.push_back(horner_eval(point_x));
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          point_x  <= pending_points.pop_front();
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 4) == 0)
            tx_gap = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result beat with the oldest prediction
  always @(posedge clk) begin
    poly_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%h ovf=%b",
                                    poly_value, overflow));
        end else begin
          want = expected_values.pop_front();
          if (poly_value !== want.value)
            report_mismatch($sformatf("poly_value got %h want %h",
                                      poly_value, want.value));
          if (overflow !== want.ovf)
            report_mismatch($sformatf("overflow got %b want %b", overflow, want.ovf));
        end
      end
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0)
          rx_gap = $urandom_range(1, 10);
      end
    end
  end

  // Long receiver hold-off once a batch is queued, so the chain fills and stalls
  initial begin
    do @(posedge clk);
    while (!(accepted_cnt >= 15 && pending_points.size() >= 30));
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYC) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Stimulus
  initial begin
    int n;
    int cscale;
    int xscale;
    int random_sent;
    int k;
    for (k = 0; k <= MAX_DEGREE; k++)
      cur_coeff[k] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset configuration: constant zero
    push_point(WORD_MAX);
    push_point(WORD_MIN);
    drain();

    // Degree zero, upper bits of the degree write ignored
    write_reg(REG_DEGREE, 32'hFFFF_FFF8);
    write_reg(REG_COEFF_BASE, WORD_MIN);
    @(negedge clk);
    push_point('0);
    push_point(WORD_MAX);
    drain();

    // Degree 7 clamps to 6, all coefficients one
    write_reg(REG_DEGREE, 32'd7);
    for (k = 0; k <= MAX_DEGREE; k++)
      write_reg(IDX_W'(REG_COEFF_BASE + k), Q_ONE);
    @(negedge clk);
    push_point(Q_ONE);
    push_point(-Q_ONE);
    push_point('0);
    push_point(32'sh0000_8000);
    push_point(WORD_MAX);
    push_point(WORD_MIN);
    drain();

    // Linear, positive extremes: positive saturation and floor on negatives
    write_reg(REG_DEGREE, 32'd1);
    write_reg(IDX_W'(REG_COEFF_BASE + 1), WORD_MAX);
    write_reg(REG_COEFF_BASE, WORD_MAX);
    @(negedge clk);
    push_point(Q_ONE);
    push_point(-Q_ONE);
    push_point(-32'sd1);
    drain();

    // Linear, negative extremes: negative saturation, largest product
    write_reg(IDX_W'(REG_COEFF_BASE + 1), WORD_MIN);
    write_reg(REG_COEFF_BASE, WORD_MIN);
    @(negedge clk);
    push_point(Q_ONE);
    push_point(WORD_MIN);
    drain();

    // Quadratic: first step clamps, later step continues from the limit
    write_reg(REG_DEGREE, 32'd2);
    write_reg(IDX_W'(REG_COEFF_BASE + 2), WORD_MAX);
    write_reg(IDX_W'(REG_COEFF_BASE + 1), WORD_MIN);
    write_reg(REG_COEFF_BASE, '0);
    @(negedge clk);
    push_point(WORD_MAX);
    push_point(2 * Q_ONE);
    drain();

    // Random phases, each with a fresh register set
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      n = (random_sent == 0) ? $urandom_range(40, 60) : $urandom_range(30, 60);
      cscale = ($urandom_range(0, 5) == 0) ? 31 : $urandom_range(12, 22);
      xscale = $urandom_range(14, 18);
      write_reg(REG_DEGREE, $urandom);
      for (k = 0; k <= MAX_DEGREE; k++)
        write_reg(IDX_W'(REG_COEFF_BASE + k), rand_scaled(cscale));
      if (random_sent >= RANDOM_ITEMS - 70)
        calm = 1'b1;
      @(negedge clk);
      for (k = 0; k < n; k++)
        push_point(($urandom_range(0, 7) == 0) ? word_t'($urandom) : rand_scaled(xscale));
      random_sent += n;
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && expected_values.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
